// ----- rtl/pag_pkg.sv -----
package pag_pkg;

   // Fixed field widths
   localparam int ADDR_W       = 48;
   localparam int SIZE_W       = 16;
   localparam int OFFSET_W     = 32;
   localparam int COUNT_W      = 32;
   localparam int PINDEX_W     = 4;
   localparam int CSR_DATA_W   = 48;

   // Register reset values
   localparam logic [ADDR_W-1:0] MAX_ADDRESS_RESET  = 48'd100000;
   localparam logic [SIZE_W-1:0] REQUEST_SIZE_RESET = 16'd8;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_LOAD     = 2'd0,
      KIND_START    = 2'd1,
      KIND_GENERATE = 2'd2,
      KIND_NONE     = 2'd3
   } kind_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MAX_ADDRESS  = 2'd0,
      CSR_REQUEST_SIZE = 2'd1,
      CSR_IS_SCATTER   = 2'd2,
      CSR_ARRAY_GAP    = 2'd3
   } csr_index_type;

   typedef struct packed {
      kind_type                     kind;
      logic [PINDEX_W-1:0]          pattern_index;
      logic signed [OFFSET_W-1:0]   pattern_offset;
      logic [COUNT_W-1:0]           issue_count;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size;
      logic              is_write;
      logic              last;
      logic              finished;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic table_write;
      logic start;
      logic idx_clear;
      logic idx_inc;
      logic wrap;
      logic update;
      logic gap;
   } pag_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic last;
   } pag_status_type;

endpackage

// ----- rtl/pag_ctrl.sv -----
module pag_ctrl
   import pag_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  kind_type       req_kind,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output pag_cmd_type    cmd,
   input  pag_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_EMIT,
      ST_GAP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign req_accept = req_valid && !req_stall;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_kind)
                  KIND_LOAD:  cmd.table_write = 1'b1;
                  KIND_START: cmd.start = 1'b1;
                  KIND_GENERATE: begin
                     cmd.idx_clear = 1'b1;
                     state_in      = ST_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            // The table read is issued here; the wrap check runs alongside.
            if (status.count_zero) begin
               state_in = ST_GAP;
            end else begin
               cmd.wrap = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (status.last) begin
                  state_in = ST_GAP;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_GAP: begin
            cmd.gap  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/pag_datapath.sv -----
module pag_datapath
   import pag_pkg::*;
#(
   parameter int PATTERN_LEN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  pag_cmd_type           cmd,
   output pag_status_type        status
);

   localparam int IDX_W = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PATTERN_LEN - 1);

   // Configuration registers
   logic [ADDR_W-1:0]          max_address_ff;
   logic [SIZE_W-1:0]          request_size_ff;
   logic                       is_scatter_ff;
   logic signed [OFFSET_W-1:0] array_gap_ff;

   // Walk state
   logic [ADDR_W-1:0]          address_ff;
   logic [ADDR_W-1:0]          address_in;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_dec;
   logic [IDX_W-1:0]           idx_ff;
   logic [OFFSET_W-1:0]        rd_data_ff;
   rsp_payload_type            out_ff;

   // Offset table
   logic [OFFSET_W-1:0]        table_mem [PATTERN_LEN];
   logic [7:0]                 wr_idx_wide;
   logic [IDX_W-1:0]           wr_addr;
   logic                       wr_in_range;

   // Offset add with clamp at zero
   logic [ADDR_W:0]            offset_sum;
   logic                       offset_neg;
   logic [ADDR_W-1:0]          updated_address;

   assign wr_idx_wide = 8'(req_payload.pattern_index);
   assign wr_addr     = wr_idx_wide[IDX_W-1:0];
   assign wr_in_range = (32'(req_payload.pattern_index) < 32'(PATTERN_LEN));

   assign offset_neg = rd_data_ff[OFFSET_W-1];
   assign offset_sum = {1'b0, address_ff}
                     + {{(ADDR_W + 1 - OFFSET_W){offset_neg}}, rd_data_ff};
   // For a negative offset a set top bit means the magnitude exceeded the address.
   assign updated_address = (offset_neg && offset_sum[ADDR_W]) ? '0
                                                               : offset_sum[ADDR_W-1:0];
   assign count_dec = count_ff - 1'b1;

   // Running address next value
   always_comb begin
      address_in = address_ff;
      if (cmd.start) begin
         address_in = '0;
      end else if (cmd.wrap) begin
         if (address_ff >= max_address_ff) begin
            address_in = '0;
         end
      end else if (cmd.update) begin
         address_in = updated_address;
      end else if (cmd.gap) begin
         address_in = address_ff + {{(ADDR_W - OFFSET_W){array_gap_ff[OFFSET_W-1]}},
                                    array_gap_ff};
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_address_ff  <= MAX_ADDRESS_RESET;
         request_size_ff <= REQUEST_SIZE_RESET;
         is_scatter_ff   <= 1'b0;
         array_gap_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_ADDRESS:  max_address_ff  <= csr_data[ADDR_W-1:0];
            CSR_REQUEST_SIZE: request_size_ff <= csr_data[SIZE_W-1:0];
            CSR_IS_SCATTER:   is_scatter_ff   <= csr_data[0];
            CSR_ARRAY_GAP:    array_gap_ff    <= csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // Address and remaining count
   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff <= '0;
         count_ff   <= '0;
      end else begin
         address_ff <= address_in;
         if (cmd.start) begin
            count_ff <= req_payload.issue_count;
         end else if (cmd.update) begin
            count_ff <= count_dec;
         end
      end
   end

   // Table walk index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Offset table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.table_write && wr_in_range) begin
         table_mem[wr_addr] <= req_payload.pattern_offset;
      end
      rd_data_ff <= table_mem[idx_ff];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         out_ff.address  <= updated_address;
         out_ff.size     <= request_size_ff;
         out_ff.is_write <= is_scatter_ff;
         out_ff.finished <= (count_dec == '0);
         out_ff.last     <= (count_dec == '0) || (idx_ff == IDX_LAST);
      end
   end

   assign rsp_payload       = out_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.last       = out_ff.last;

endmodule

// ----- rtl/pattern_address_generator.sv -----
// Load and start items produce no beat. A generate item is accepted, then each request
// of the pass takes a table read with wrap check, an offset add and a result beat, and a
// gap add ends the pass; a pass that starts with the count already at zero goes straight
// to the gap add. A stalled beat is held until the stall clears.
// Synchronous reset clears the running address and count and restores register defaults;
// the offset table is not cleared and holds no data until loaded.
module pattern_address_generator
   import pag_pkg::*;
#(
   parameter int PATTERN_LEN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   pag_cmd_type    cmd;
   pag_status_type status;

   // Sequencer
   pag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_payload.kind),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Address datapath, offset table and registers
   pag_datapath #(
      .PATTERN_LEN (PATTERN_LEN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ----- sim/tb_pattern_address_generator.sv -----
`timescale 1ns / 1ps

module tb_pattern_address_generator;
   import pag_pkg::*;

   localparam int TABLE_DEPTH = 16;
   // Long enough to cover a generate pass that emits nothing.
   localparam int DRAIN_CYCLES = 64;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_MAX_ADDRESS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copy of the block: offset table, walk state and registers.
   logic [OFFSET_W-1:0] offset_shadow [TABLE_DEPTH];
   logic [ADDR_W-1:0]   walk_address = '0;
   logic [COUNT_W-1:0]  requests_left = '0;
   logic [ADDR_W-1:0]   max_address_cfg = MAX_ADDRESS_RESET;
   logic [SIZE_W-1:0]   request_size_cfg = REQUEST_SIZE_RESET;
   logic                scatter_cfg = 1'b0;
   logic [OFFSET_W-1:0] array_gap_cfg = '0;

   rsp_payload_type expected_requests[$];
   rsp_payload_type want;
   int              error_count = 0;
   int              items_sent = 0;
   bit              idling_enabled = 1'b1;
   int              stall_left = 0;

   pattern_address_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Most gaps are short, a few are long, and none when idling is switched off.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idling_enabled || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Apply one accepted item to the shadow state and queue the requests it causes.
   function automatic void predict_request_item(input req_payload_type item);
      rsp_payload_type     beat;
      logic [OFFSET_W-1:0] offset;
      logic [ADDR_W-1:0]   magnitude;
      int                  n;
      case (item.kind)
         KIND_LOAD: begin
            offset_shadow[item.pattern_index] = item.pattern_offset;
         end
         KIND_START: begin
            requests_left = item.issue_count;
            walk_address = '0;
         end
         KIND_GENERATE: begin
            n = (requests_left < TABLE_DEPTH) ? int'(requests_left) : TABLE_DEPTH;
            for (int i = 0; i < n; i++) begin
               offset = offset_shadow[i];
               if (walk_address >= max_address_cfg) walk_address = '0;
               if (offset[OFFSET_W-1]) begin
                  // Negation of the most negative offset gives 2^31 as an unsigned value.
                  magnitude = {16'd0, -offset};
                  if (walk_address < magnitude) walk_address = '0;
                  else walk_address = walk_address - magnitude;
               end else begin
                  walk_address = walk_address + {16'd0, offset};
               end
               requests_left = requests_left - 1;
               beat.address = walk_address;
               beat.size = request_size_cfg;
               beat.is_write = scatter_cfg;
               beat.last = (i == n - 1);
               beat.finished = (requests_left == 0);
               expected_requests = {expected_requests, beat};
            end
            // The gap is added even when the pass emits nothing.
            walk_address = walk_address + {{16{array_gap_cfg[OFFSET_W-1]}}, array_gap_cfg};
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %h, got %h", name, expected, actual);
         error_count++;
      end
   endfunction

   // Random content in every field but the kind, so that unused fields toggle too.
   function automatic req_payload_type make_item(input kind_type kind);
      req_payload_type item;
      item.kind = kind;
      item.pattern_index = PINDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
      item.pattern_offset = $urandom;
      item.issue_count = $urandom;
      return item;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 85) return $urandom_range(1, 70);
      if (roll < 92) return 32'd16 * $urandom_range(1, 4);
      return $urandom;
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return $urandom_range(0, 4000) - 2000;
      if (roll < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         default: return 32'h0000_0000;
      endcase
   endfunction

   // Sends one beat; valid stays high after acceptance unless a gap follows.
   task automatic send_beat(input req_payload_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predict_request_item(item);
      if (item.kind != KIND_NONE) items_sent++;
   endtask

   // Waits until every expected request has arrived and the block has gone quiet.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_requests.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_MAX_ADDRESS:  max_address_cfg = value[ADDR_W-1:0];
         CSR_REQUEST_SIZE: request_size_cfg = value[SIZE_W-1:0];
         CSR_IS_SCATTER:   scatter_cfg = value[0];
         CSR_ARRAY_GAP:    array_gap_cfg = value[OFFSET_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(input logic [ADDR_W-1:0] max_address,
                                 input logic [SIZE_W-1:0] size, input logic scatter,
                                 input logic [OFFSET_W-1:0] gap);
      settle_block();
      write_csr(CSR_MAX_ADDRESS, max_address);
      write_csr(CSR_REQUEST_SIZE, {32'd0, size});
      write_csr(CSR_IS_SCATTER, {47'd0, scatter});
      write_csr(CSR_ARRAY_GAP, {16'd0, gap});
   endtask

   // Fill the whole table with edge offsets, then walk it with reset register values.
   task automatic test_table_load_and_walk();
      logic [OFFSET_W-1:0] edge_offsets [TABLE_DEPTH];
      req_payload_type     item;
      edge_offsets = '{32'h0000_0005, 32'hFFFF_FFFD, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_0064, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                       32'h0001_86A0, 32'hFFFE_7960, 32'h0000_0FFF, 32'h8000_0001,
                       32'h0000_0010, 32'hFFFF_FF00, 32'h5555_5555, 32'hAAAA_AAAA};
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         item = make_item(KIND_LOAD);
         item.pattern_index = PINDEX_W'(i);
         item.pattern_offset = edge_offsets[i];
         send_beat(item);
      end
      // The unused kind must be ignored.
      send_beat(make_item(KIND_NONE));
      // Two full passes, a partial one, then one with the count already used up.
      item = make_item(KIND_START);
      item.issue_count = 32'd40;
      send_beat(item);
      repeat (4) send_beat(make_item(KIND_GENERATE));
      // A zero count emits nothing but still moves the address by the gap.
      item = make_item(KIND_START);
      item.issue_count = '0;
      send_beat(item);
      send_beat(make_item(KIND_GENERATE));
      item = make_item(KIND_START);
      item.issue_count = 32'hFFFF_FFFF;
      send_beat(item);
      send_beat(make_item(KIND_GENERATE));
   endtask

   // Each register at its extremes and at middling values, with a short walk after every setting.
   task automatic test_register_extremes();
      req_payload_type item;
      for (int setting = 0; setting < 4; setting++) begin
         case (setting)
            0: apply_settings(48'd0, 16'd1, 1'b1, 32'h8000_0000);
            1: apply_settings(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, 32'h7FFF_FFFF);
            // A negative gap from a small address lands near the top of the address space.
            2: apply_settings(48'hFFFF_FFFF_FFFF, 16'h00A5, 1'b1, 32'hFFFF_FFF0);
            default: apply_settings(48'd300, 16'd64, 1'b0, 32'd7);
         endcase
         idling_enabled = (setting != 1);
         item = make_item(KIND_START);
         item.issue_count = $urandom_range(20, 48);
         send_beat(item);
         repeat (3) send_beat(make_item(KIND_GENERATE));
      end
      idling_enabled = 1'b1;
   endtask

   // Mostly start-and-walk sequences, with reloads, noise and stray generates mixed in.
   task automatic test_random_traffic();
      req_payload_type   item;
      logic [ADDR_W-1:0] max_address;
      int                target;
      int                roll;
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0: max_address = ADDR_W'($urandom_range(100, 20000));
            1: max_address = ADDR_W'({$urandom, $urandom});
            2: max_address = '1;
            default: max_address = ADDR_W'($urandom_range(0, 50));
         endcase
         apply_settings(max_address, SIZE_W'($urandom_range(1, 65535)),
                        1'($urandom_range(0, 1)),
                        ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000) - 1000
                                                     : $urandom);
         idling_enabled = (phase != 2);
         target = items_sent + 28;
         while (items_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               item = make_item(KIND_START);
               item.issue_count = pick_count();
               send_beat(item);
               repeat ($urandom_range(1, 5)) send_beat(make_item(KIND_GENERATE));
            end else if (roll < 85) begin
               item = make_item(KIND_LOAD);
               item.pattern_offset = pick_offset();
               send_beat(item);
            end else if (roll < 93) begin
               send_beat(make_item(KIND_NONE));
            end else begin
               send_beat(make_item(KIND_GENERATE));
            end
         end
      end
      idling_enabled = 1'b1;
   endtask

   // Receiver stalls in runs of random length.
   always @(negedge clock) begin
      if (stall_left == 0 && idling_enabled && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // Every accepted request beat is checked against the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_requests.size() == 0) begin
            $error("request beat with none expected: address %h", rsp_payload.address);
            error_count++;
         end else begin
            want = expected_requests.pop_front();
            check_field("address", 64'(want.address), 64'(rsp_payload.address));
            check_field("size", 64'(want.size), 64'(rsp_payload.size));
            check_field("is_write", 64'(want.is_write), 64'(rsp_payload.is_write));
            check_field("last", 64'(want.last), 64'(rsp_payload.last));
            check_field("finished", 64'(want.finished), 64'(rsp_payload.finished));
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_table_load_and_walk();
      test_register_extremes();
      test_random_traffic();
      settle_block();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pag_pkg.sv
rtl/pag_ctrl.sv
rtl/pag_datapath.sv
rtl/pattern_address_generator.sv
sim/tb_pattern_address_generator.sv
